/* sv/vn1c_pkg.sv */
// ----------------------------------------------------------------------------
// vn1c_pkg
// Shared constants, types and the cosine weight table for the 1-D value noise
// core.
// ----------------------------------------------------------------------------
package vn1c_pkg;

  localparam int FRAC_BITS         = 16;
  localparam int WEIGHT_INDEX_BITS = 8;
  localparam int COORD_W           = 48;
  localparam int NOISE_W           = 32;
  localparam int WEIGHT_W          = 16;
  localparam int ROM_DEPTH         = 1 << WEIGHT_INDEX_BITS;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  localparam logic [31:0] HASH_MUL   = 32'd15731;
  localparam logic [31:0] HASH_ADD_A = 32'd789221;
  localparam logic [31:0] HASH_ADD_R = 32'd1376312589;
  localparam int          HASH_SHIFT = 13;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [NOISE_W-1:0]  noise_t;
  typedef logic [WEIGHT_W-1:0]        weight_t;
  typedef weight_t [ROM_DEPTH-1:0]    weight_rom_t;

  // Truncating unsigned division by shift and subtract, used only while the
  // weight table is built.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Builds sin^2(pi*i/(2*ROM_DEPTH)) in Q0.16 from a Q2.30 Taylor series.
  function automatic weight_rom_t build_weight_rom();
    weight_rom_t rom;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] w;
    logic [63:0] kk;
    logic neg;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      t    = (HALF_PI_Q30 * 64'(i)) >> WEIGHT_INDEX_BITS;
      t2   = (t * t) >> 30;
      term = t;
      sum  = $signed(t);
      neg  = 1'b1;
      for (int k = 3; k <= 13; k += 2) begin
        kk   = 64'(k * (k - 1));
        term = udiv64((term * t2) >> 30, kk);
        if (neg) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
        neg = !neg;
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      if (sum > $signed(ONE_Q30)) begin
        sum = $signed(ONE_Q30);
      end
      w = ($unsigned(sum) * $unsigned(sum) + (64'd1 << 43)) >> 44;
      if (w > 64'd65535) begin
        w = 64'd65535;
      end
      rom[i] = w[WEIGHT_W-1:0];
    end
    return rom;
  endfunction

endpackage

/* sv/vn1c_if.sv */
// ----------------------------------------------------------------------------
// vn1c_in_if / vn1c_out_if
// Valid/ready request channels for coordinates and noise values.
// ----------------------------------------------------------------------------
interface vn1c_in_if;
  logic            valid;
  logic            ready;
  vn1c_pkg::coord_t coordinate;

  modport source (output valid, output coordinate, input ready);
  modport sink   (input valid, input coordinate, output ready);
endinterface

interface vn1c_out_if;
  logic            valid;
  logic            ready;
  vn1c_pkg::noise_t noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface

/* sv/value_noise_1d_cosine_core.sv */
// ----------------------------------------------------------------------------
// value_noise_1d_cosine_core
// Seven-stage pipeline: a new coordinate request is taken every cycle unless a
// stalled output has filled all stages. The depth is set by the lattice hash,
// whose three dependent 32-bit multiplies and the blend multiply each own a
// stage. Each stage stalls only when it holds data that the next cannot take,
// so bubbles collapse and a stalled output still lets earlier stages fill.
// ----------------------------------------------------------------------------
module value_noise_1d_cosine_core (
  input  logic clk,
  input  logic rst_n,
  vn1c_in_if.sink    in_ch,
  vn1c_out_if.source out_ch
);

  localparam int FB  = vn1c_pkg::FRAC_BITS;
  localparam int WIB = vn1c_pkg::WEIGHT_INDEX_BITS;
  localparam int NS  = 7;
  localparam vn1c_pkg::weight_rom_t WEIGHT_ROM = vn1c_pkg::build_weight_rom();

  logic [NS:1] v_r;
  logic [NS:1] en;

  always_comb begin
    en[NS] = !v_r[NS] || out_ch.ready;
    for (int i = NS - 1; i >= 1; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ch.ready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_ch.valid;
      end
      for (int i = 2; i <= NS; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Stage 1: lattice split, hash prefix and weight lookup.
  logic [63:0]            coord_ext;
  logic [31:0]            n0;
  logic [31:0]            n1;
  logic [FB-1:0]          frac;
  logic [FB+WIB-1:0]      frac_pad;
  logic [WIB-1:0]         widx;
  logic [31:0]            h0_nxt, h1_nxt;
  logic [31:0]            h0_1_r, h1_1_r;
  vn1c_pkg::weight_t      w_1_r;

  always_comb begin
    coord_ext = 64'(in_ch.coordinate);
    n0        = coord_ext[FB+31:FB];
    n1        = n0 + 32'd1;
    frac      = coord_ext[FB-1:0];
    frac_pad  = {frac, WIB'(0)};
    widx      = frac_pad[FB+WIB-1 -: WIB];
    h0_nxt    = (n0 << vn1c_pkg::HASH_SHIFT) ^ n0;
    h1_nxt    = (n1 << vn1c_pkg::HASH_SHIFT) ^ n1;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      h0_1_r <= h0_nxt;
      h1_1_r <= h1_nxt;
      w_1_r  <= WEIGHT_ROM[widx];
    end
  end

  // Stage 2: h*h.
  logic [31:0]       hh0_2_r, hh1_2_r, h0_2_r, h1_2_r;
  vn1c_pkg::weight_t w_2_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      hh0_2_r <= h0_1_r * h0_1_r;
      hh1_2_r <= h1_1_r * h1_1_r;
      h0_2_r  <= h0_1_r;
      h1_2_r  <= h1_1_r;
      w_2_r   <= w_1_r;
    end
  end

  // Stage 3: a = h*h*15731 + 789221.
  logic [31:0]       a0_3_r, a1_3_r, h0_3_r, h1_3_r;
  vn1c_pkg::weight_t w_3_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      a0_3_r <= hh0_2_r * vn1c_pkg::HASH_MUL + vn1c_pkg::HASH_ADD_A;
      a1_3_r <= hh1_2_r * vn1c_pkg::HASH_MUL + vn1c_pkg::HASH_ADD_A;
      h0_3_r <= h0_2_r;
      h1_3_r <= h1_2_r;
      w_3_r  <= w_2_r;
    end
  end

  // Stage 4: r = (h*a + 1376312589) masked to 31 bits.
  logic [31:0]       r0_nxt, r1_nxt;
  logic [30:0]       r0_4_r, r1_4_r;
  vn1c_pkg::weight_t w_4_r;

  assign r0_nxt = h0_3_r * a0_3_r + vn1c_pkg::HASH_ADD_R;
  assign r1_nxt = h1_3_r * a1_3_r + vn1c_pkg::HASH_ADD_R;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      r0_4_r <= r0_nxt[30:0];
      r1_4_r <= r1_nxt[30:0];
      w_4_r  <= w_3_r;
    end
  end

  // Stage 5: samples and their difference.
  logic signed [31:0] s0_nxt, s1_nxt;
  logic signed [31:0] s0_5_r;
  logic signed [32:0] diff_5_r;
  vn1c_pkg::weight_t  w_5_r;

  assign s0_nxt = 32'sh4000_0000 - $signed({1'b0, r0_4_r});
  assign s1_nxt = 32'sh4000_0000 - $signed({1'b0, r1_4_r});

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s0_5_r   <= s0_nxt;
      diff_5_r <= 33'(s1_nxt) - 33'(s0_nxt);
      w_5_r    <= w_4_r;
    end
  end

  // Stage 6: blend product.
  logic signed [49:0] prod_6_r;
  logic signed [31:0] s0_6_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      prod_6_r <= 50'(diff_5_r) * 50'($signed({1'b0, w_5_r}));
      s0_6_r   <= s0_5_r;
    end
  end

  // Stage 7: floor shift and final add into the output register.
  logic signed [33:0] res_nxt;
  logic signed [33:0] prod_sh;
  vn1c_pkg::noise_t   res_7_r;

  assign prod_sh = 34'(prod_6_r >>> 16);
  assign res_nxt = 34'(s0_6_r) + prod_sh;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      res_7_r <= res_nxt[31:0];
    end
  end

  assign out_ch.valid       = v_r[NS];
  assign out_ch.noise_value = res_7_r;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 1-D cosine value noise core. A queue of
// coordinates feeds a valid/ready driver, and a monitor compares every noise
// value with a fixed-point prediction of the lattice hash and cosine blend.
// Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          RANDOM_ITEMS  = 1182;
  localparam int          QUIET_TAIL    = 200;
  localparam int          SETTLE_CYCLES = 30;
  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          BLEND_SHIFT   = 16;
  localparam logic [63:0] QUARTER_TURN  = 64'd1686629713;
  localparam logic [63:0] UNIT_Q30      = 64'd1073741824;
  localparam logic [63:0] WEIGHT_MAX    = 64'd65535;
  localparam logic [31:0] MIX_MUL       = 32'd15731;
  localparam logic [31:0] MIX_ADD       = 32'd789221;
  localparam logic [31:0] MIX_OFFSET    = 32'd1376312589;
  localparam logic [31:0] HASH_MASK     = 32'h7FFF_FFFF;

  typedef struct {
    vn1c_pkg::coord_t coord;
    vn1c_pkg::noise_t value;
  } noise_check_t;

  logic clk;
  logic rst_n;

  vn1c_in_if  in_ch ();
  vn1c_out_if out_ch ();

  value_noise_1d_cosine_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  vn1c_pkg::coord_t coord_q[$];
  noise_check_t     expected_q[$];
  int               total_items;
  int               drain_point;
  int               sent_cnt;
  int               checked_cnt;
  int               error_cnt;
  int               cycle_cnt;
  int               in_gap;
  int               out_gap;
  bit               drained;

  function automatic logic [vn1c_pkg::WEIGHT_W-1:0] cos_weight(int unsigned idx);
    logic [63:0]        t;
    logic [63:0]        t2;
    logic [63:0]        term;
    logic [63:0]        w;
    logic signed [63:0] acc;
    t    = (QUARTER_TURN * 64'(idx)) >> vn1c_pkg::WEIGHT_INDEX_BITS;
    t2   = (t * t) >> 30;
    term = t;
    acc  = $signed(t);
    for (int k = 3; k <= 13; k += 2) begin
      term = ((term * t2) >> 30) / 64'(k * (k - 1));
      if (k % 4 == 3) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = 64'sd0;
    end
    if (acc > $signed(UNIT_Q30)) begin
      acc = $signed(UNIT_Q30);
    end
    w = ($unsigned(acc) * $unsigned(acc) + (64'd1 << 43)) >> 44;
    if (w > WEIGHT_MAX) begin
      w = WEIGHT_MAX;
    end
    return w[vn1c_pkg::WEIGHT_W-1:0];
  endfunction

  function automatic logic signed [63:0] lattice_value(logic [31:0] n);
    logic [31:0] h;
    logic [31:0] a;
    logic [31:0] r;
    h = (n << 13) ^ n;
    a = h * h * MIX_MUL + MIX_ADD;
    r = (h * a + MIX_OFFSET) & HASH_MASK;
    return $signed(UNIT_Q30) - $signed({32'd0, r});
  endfunction

  function automatic vn1c_pkg::noise_t predict_noise(vn1c_pkg::coord_t c);
    logic [31:0]                            n;
    logic [vn1c_pkg::WEIGHT_INDEX_BITS-1:0] idx;
    logic signed [63:0]                     s0;
    logic signed [63:0]                     s1;
    logic signed [63:0]                     prod;
    logic signed [63:0]                     res;
    n    = c[vn1c_pkg::FRAC_BITS +: 32];
    idx  = c[vn1c_pkg::FRAC_BITS-1 -: vn1c_pkg::WEIGHT_INDEX_BITS];
    s0   = lattice_value(n);
    s1   = lattice_value(n + 32'd1);
    prod = (s1 - s0) * $signed({48'd0, cos_weight(idx)});
    res  = s0 + (prod >>> BLEND_SHIFT);
    return res[vn1c_pkg::NOISE_W-1:0];
  endfunction

  function automatic vn1c_pkg::coord_t make_coord(logic [31:0] n,
                                                  logic [vn1c_pkg::FRAC_BITS-1:0] f);
    return vn1c_pkg::coord_t'({n, f});
  endfunction

  function automatic vn1c_pkg::coord_t random_coord();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return vn1c_pkg::coord_t'(r[vn1c_pkg::COORD_W-1:0]);
  endfunction

  function automatic bit idling_allowed(int n);
    return (n < total_items - QUIET_TAIL) && ((n / 160) % 4 != 3);
  endfunction

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  always @(posedge clk) begin : drive_coords
    int           accepted;
    noise_check_t entry;
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.coordinate <= '0;
      in_gap           <= 0;
    end else begin
      accepted = sent_cnt;
      if (in_ch.valid && in_ch.ready) begin
        entry.coord = in_ch.coordinate;
        entry.value = predict_noise(in_ch.coordinate);
        expected_q.push_back(entry);
        accepted++;
      end
      sent_cnt <= accepted;
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap != 0) begin
          in_gap      <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (accepted == drain_point && !drained) begin
          in_ch.valid <= 1'b0;
          if (expected_q.size() == 0) begin
            drained <= 1'b1;
          end
        end else if (coord_q.size() != 0 && idling_allowed(accepted) &&
                     $urandom_range(0, 9) == 0) begin
          in_gap      <= $urandom_range(0, 8);
          in_ch.valid <= 1'b0;
        end else if (coord_q.size() != 0) begin
          in_ch.valid      <= 1'b1;
          in_ch.coordinate <= coord_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_noise
    noise_check_t entry;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap      <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected noise value, expected none, actual %0d",
                   $time, out_ch.noise_value);
          error_cnt <= error_cnt + 1;
        end else begin
          entry = expected_q.pop_front();
          checked_cnt <= checked_cnt + 1;
          if (out_ch.noise_value !== entry.value) begin
            $display("%0t: noise mismatch at coordinate %h, expected %0d, actual %0d",
                     $time, entry.coord, entry.value, out_ch.noise_value);
            error_cnt <= error_cnt + 1;
          end
        end
      end
      if (out_gap != 0) begin
        out_gap      <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (idling_allowed(sent_cnt) && $urandom_range(0, 9) == 0) begin
        out_gap      <= $urandom_range(0, 8);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
    end
    $display("[value_noise_1d_cosine_core] ERROR");
    $finish;
  end

  initial begin
    logic [31:0]                    n;
    logic [vn1c_pkg::FRAC_BITS-1:0] f;
    int                             pick;
    clk              = 1'b0;
    rst_n            = 1'b0;
    sent_cnt         = 0;
    checked_cnt      = 0;
    error_cnt        = 0;
    cycle_cnt        = 0;
    drained          = 1'b0;

    coord_q.push_back(vn1c_pkg::coord_t'(48'h0000_0000_0000));
    coord_q.push_back(vn1c_pkg::coord_t'(48'h0000_0000_0001));
    coord_q.push_back(vn1c_pkg::coord_t'(48'h0000_0000_00FF));
    coord_q.push_back(vn1c_pkg::coord_t'(48'h0000_0000_0100));
    coord_q.push_back(vn1c_pkg::coord_t'(48'h0000_0000_8000));
    coord_q.push_back(vn1c_pkg::coord_t'(48'h0000_0000_FF00));
    coord_q.push_back(vn1c_pkg::coord_t'(48'h0000_0000_FFFF));
    coord_q.push_back(vn1c_pkg::coord_t'(48'h0000_0001_0000));
    coord_q.push_back(vn1c_pkg::coord_t'(48'hFFFF_FFFF_FFFF));
    coord_q.push_back(vn1c_pkg::coord_t'(48'hFFFF_FFFF_0000));
    coord_q.push_back(vn1c_pkg::coord_t'(48'hFFFF_FFFF_8000));
    coord_q.push_back(vn1c_pkg::coord_t'(48'h7FFF_FFFF_FFFF));
    coord_q.push_back(vn1c_pkg::coord_t'(48'h7FFF_FFFF_0000));
    coord_q.push_back(vn1c_pkg::coord_t'(48'h8000_0000_0000));
    coord_q.push_back(vn1c_pkg::coord_t'(48'h8000_0000_FFFF));
    coord_q.push_back(vn1c_pkg::coord_t'(48'h5555_5555_5555));
    coord_q.push_back(vn1c_pkg::coord_t'(48'hAAAA_AAAA_AAAA));
    coord_q.push_back(vn1c_pkg::coord_t'(48'h0000_8000_FF80));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      n = $urandom();
      f = vn1c_pkg::FRAC_BITS'($urandom());
      if (i < vn1c_pkg::ROM_DEPTH) begin
        f[vn1c_pkg::FRAC_BITS-1 -: vn1c_pkg::WEIGHT_INDEX_BITS] =
          vn1c_pkg::WEIGHT_INDEX_BITS'(i);
        coord_q.push_back(make_coord(n, f));
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          coord_q.push_back(random_coord());
        end else if (pick < 7) begin
          case ($urandom_range(0, 3))
            0: n = 32'h0000_0000;
            1: n = 32'h7FFF_FFFF;
            2: n = 32'hFFFF_FFFF;
            default: n = 32'h8000_0000;
          endcase
          n = n + 32'($urandom_range(0, 4)) - 32'd2;
          coord_q.push_back(make_coord(n, f));
        end else begin
          case ($urandom_range(0, 2))
            0: f = '0;
            1: f = '1;
            default: f = {{vn1c_pkg::WEIGHT_INDEX_BITS{1'b1}},
                          f[vn1c_pkg::FRAC_BITS-vn1c_pkg::WEIGHT_INDEX_BITS-1:0]};
          endcase
          coord_q.push_back(make_coord(n, f));
        end
      end
    end
    total_items = coord_q.size();
    drain_point = total_items / 2;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_cnt != total_items || expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Summary: %0d coordinates sent and %0d noise values compared.",
             total_items, checked_cnt);
    $display("Covered field extremes, lattice wrap and all %0d weight indices.",
             vn1c_pkg::ROM_DEPTH);
    if (error_cnt == 0) begin
      $display("[value_noise_1d_cosine_core] OK");
    end else begin
      $display("[value_noise_1d_cosine_core] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
sv/vn1c_pkg.sv
sv/vn1c_if.sv
sv/value_noise_1d_cosine_core.sv
tb/sv/testbench.sv
